// ===== sv/pdq_pkg.sv =====
// Shared constants, types and helpers for the priority drop queue admission unit.
package pdq_pkg;

    localparam int QUEUE_SLOTS   = 256;
    localparam int BARRIER_SLOTS = 64;

    localparam int IDX_W     = $clog2(QUEUE_SLOTS);
    localparam int CNT_W     = $clog2(QUEUE_SLOTS + 1);
    localparam int CMP_W     = (CNT_W > 9) ? CNT_W : 9;
    localparam int BS_CNT_W  = $clog2(BARRIER_SLOTS + 1);
    localparam int BS_IDX_W  = (BARRIER_SLOTS > 1) ? $clog2(BARRIER_SLOTS) : 1;

    localparam logic [1:0] CMD_ENQ   = 2'd0;
    localparam logic [1:0] CMD_DEQ   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [2:0] TYPE_REQ_LOG  = 3'd3;
    localparam logic [2:0] TYPE_RESP_LOG = 3'd4;
    localparam logic [2:0] TYPE_BARRIER  = 3'd5;

    localparam logic [3:0] ST_ACCEPTED      = 4'd0;
    localparam logic [3:0] ST_EVICTED       = 4'd1;
    localparam logic [3:0] ST_LOG_DROPPED   = 4'd2;
    localparam logic [3:0] ST_NOT_ACCEPTING = 4'd3;
    localparam logic [3:0] ST_AFTER_BARRIER = 4'd4;
    localparam logic [3:0] ST_FULL          = 4'd5;
    localparam logic [3:0] ST_POPPED        = 4'd6;
    localparam logic [3:0] ST_EMPTY         = 4'd7;
    localparam logic [3:0] ST_CLOSED        = 4'd8;
    localparam logic [3:0] ST_SET_FULL      = 4'd9;

    typedef struct packed {
        logic [2:0]  item_type;
        logic        has_session;
        logic [15:0] session_id;
        logic [63:0] generation;
        logic [31:0] payload;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic       latch;
        logic       check;
        logic       rd_front;
        logic       rd_scan;
        logic       rd_copy;
        logic       wr_copy;
        logic       idx_clr;
        logic       idx_inc;
        logic       pop;
        logic       occ_dec;
        logic       append;
        logic       do_start;
        logic       do_stop;
        logic       set_status;
        logic [3:0] status;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       drain;
        logic       not_acc;
        logic       after_bar;
        logic       set_full;
        logic       over_cap;
        logic       in_log;
        logic       occ_zero;
        logic       stop_flag;
        logic       scan_log;
        logic       idx_last;
        logic       out_busy;
    } dp_stat_t;

    function automatic logic is_log(input logic [2:0] t);
        return (t == TYPE_REQ_LOG) || (t == TYPE_RESP_LOG);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(QUEUE_SLOTS)) begin
            sum = sum - (CNT_W+1)'(QUEUE_SLOTS);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== sv/pdq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/pdq_datapath.sv =====
// Queue storage, barrier set, occupancy and result registers.
module pdq_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  pdq_pkg::dp_cmd_t  cmd,
    output pdq_pkg::dp_stat_t stat,
    input  logic              cfg_wr_en,
    input  logic [8:0]        cfg_wr_data,
    input  logic [1:0]        s_cmd,
    input  logic [2:0]        s_item_type,
    input  logic [15:0]       s_session_id,
    input  logic              s_has_session,
    input  logic [63:0]       s_generation,
    input  logic [31:0]       s_payload,
    input  logic              s_drain,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [3:0]        m_status,
    output logic [2:0]        m_out_type,
    output logic [15:0]       m_out_session,
    output logic              m_out_has_session,
    output logic [63:0]       m_out_generation,
    output logic [31:0]       m_out_payload,
    output logic              m_barrier_done,
    output logic [8:0]        m_depth_now
);

    localparam int IW  = pdq_pkg::IDX_W;
    localparam int CW  = pdq_pkg::CNT_W;
    localparam int MW  = pdq_pkg::CMP_W;
    localparam int BCW = pdq_pkg::BS_CNT_W;
    localparam int BIW = pdq_pkg::BS_IDX_W;
    localparam int NB  = pdq_pkg::BARRIER_SLOTS;

    logic [1:0]          cmd_reg;
    pdq_pkg::slot_t      in_reg;
    logic                drain_reg;
    logic [NB-1:0]       hit_reg;
    logic [15:0]         tags_reg [NB];
    logic [BCW-1:0]      bs_cnt_reg;
    logic [IW-1:0]       head_reg;
    logic [CW-1:0]       occ_reg;
    logic [CW-1:0]       idx_reg;
    logic                acc_reg;
    logic                stop_reg;
    logic [8:0]          maxd_reg;
    logic [3:0]          status_reg;
    pdq_pkg::slot_t      pop_reg;
    logic                out_valid_reg;

    pdq_pkg::slot_t      rd_slot;
    logic [pdq_pkg::SLOT_W-1:0] rdata;
    logic                rd_en;
    logic [IW-1:0]       raddr;
    logic                wr_en;
    logic [IW-1:0]       waddr;
    pdq_pkg::slot_t      wdata;
    logic [MW-1:0]       lim;
    logic [MW-1:0]       cap;
    logic [MW-1:0]       occ_ext;
    logic                in_bar;
    logic [CW-1:0]       idx_nx;

    assign rd_slot = pdq_pkg::slot_t'(rdata);
    assign in_bar  = (in_reg.item_type == pdq_pkg::TYPE_BARRIER);
    assign occ_ext = MW'(occ_reg);
    assign idx_nx  = idx_reg + CW'(1);

    always_comb begin
        if (maxd_reg == 9'd0) begin
            lim = MW'(1);
        end else if (MW'(maxd_reg) > MW'(pdq_pkg::QUEUE_SLOTS)) begin
            lim = MW'(pdq_pkg::QUEUE_SLOTS);
        end else begin
            lim = MW'(maxd_reg);
        end
        if (in_bar || lim <= MW'(1)) begin
            cap = lim;
        end else begin
            cap = lim - MW'(1);
        end
    end

    always_comb begin
        rd_en = cmd.rd_front | cmd.rd_scan | cmd.rd_copy;
        if (cmd.rd_front) begin
            raddr = head_reg;
        end else if (cmd.rd_scan) begin
            raddr = pdq_pkg::wrap_idx(head_reg, idx_reg);
        end else begin
            raddr = pdq_pkg::wrap_idx(head_reg, idx_nx);
        end
        wr_en = cmd.wr_copy | cmd.append;
        if (cmd.wr_copy) begin
            waddr = pdq_pkg::wrap_idx(head_reg, idx_reg);
            wdata = rd_slot;
        end else begin
            waddr = pdq_pkg::wrap_idx(head_reg, occ_reg);
            wdata = in_reg;
        end
    end

    pdq_ram #(
        .WIDTH(pdq_pkg::SLOT_W),
        .DEPTH(pdq_pkg::QUEUE_SLOTS)
    ) u_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .re   (rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        stat.cmd       = cmd_reg;
        stat.drain     = drain_reg;
        stat.not_acc   = !acc_reg || stop_reg;
        stat.after_bar = in_reg.has_session && (|hit_reg);
        stat.set_full  = in_bar && in_reg.has_session && (bs_cnt_reg == BCW'(NB));
        stat.over_cap  = occ_ext >= cap;
        stat.in_log    = pdq_pkg::is_log(in_reg.item_type);
        stat.occ_zero  = (occ_reg == '0);
        stat.stop_flag = stop_reg;
        stat.scan_log  = pdq_pkg::is_log(rd_slot.item_type);
        stat.idx_last  = idx_nx >= occ_reg;
        stat.out_busy  = out_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            cmd_reg               <= s_cmd;
            in_reg.item_type      <= s_item_type;
            in_reg.has_session    <= s_has_session;
            in_reg.session_id     <= s_session_id;
            in_reg.generation     <= s_generation;
            in_reg.payload        <= s_payload;
            drain_reg             <= s_drain;
        end
        if (cmd.check) begin
            for (int i = 0; i < NB; i++) begin
                hit_reg[i] <= (BCW'(i) < bs_cnt_reg) && (tags_reg[i] == in_reg.session_id);
            end
        end
        if (cmd.append && in_bar && in_reg.has_session) begin
            tags_reg[bs_cnt_reg[BIW-1:0]] <= in_reg.session_id;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_nx;
        end
        if (cmd.pop) begin
            pop_reg <= rd_slot;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.load_out) begin
            logic [MW-1:0] dn;
            logic          popped;
            dn                = occ_ext;
            popped            = (status_reg == pdq_pkg::ST_POPPED);
            m_status          <= status_reg;
            m_depth_now       <= dn[8:0];
            m_out_type        <= popped ? pop_reg.item_type : 3'd0;
            m_out_session     <= popped ? pop_reg.session_id : 16'd0;
            m_out_has_session <= popped && pop_reg.has_session;
            m_out_generation  <= popped ? pop_reg.generation : 64'd0;
            m_out_payload     <= popped ? pop_reg.payload : 32'd0;
            m_barrier_done    <= popped && (pop_reg.item_type == pdq_pkg::TYPE_BARRIER);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_cnt_reg    <= '0;
            head_reg      <= '0;
            occ_reg       <= '0;
            acc_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            maxd_reg      <= 9'd256;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                maxd_reg <= cfg_wr_data;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.pop) begin
                head_reg <= pdq_pkg::wrap_idx(head_reg, CW'(1));
                occ_reg  <= occ_reg - CW'(1);
            end
            if (cmd.occ_dec) begin
                occ_reg <= occ_reg - CW'(1);
            end
            if (cmd.append) begin
                occ_reg <= occ_reg + CW'(1);
                if (in_bar && in_reg.has_session) begin
                    bs_cnt_reg <= bs_cnt_reg + BCW'(1);
                end
            end
            if (cmd.do_start && !acc_reg) begin
                occ_reg    <= '0;
                bs_cnt_reg <= '0;
                acc_reg    <= 1'b1;
                stop_reg   <= 1'b0;
            end
            if (cmd.do_stop) begin
                acc_reg  <= 1'b0;
                stop_reg <= 1'b1;
                if (!drain_reg) begin
                    occ_reg    <= '0;
                    bs_cnt_reg <= '0;
                end
            end
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== sv/pdq_ctrl.sv =====
// Command sequencer: admission decision, eviction search and compaction.
module pdq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pdq_pkg::dp_stat_t stat,
    output pdq_pkg::dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHK     = 4'd1;
    localparam logic [3:0] S_DEC     = 4'd2;
    localparam logic [3:0] S_POP     = 4'd3;
    localparam logic [3:0] S_SCAN_RD = 4'd4;
    localparam logic [3:0] S_SCAN_CK = 4'd5;
    localparam logic [3:0] S_CP_RD   = 4'd6;
    localparam logic [3:0] S_CP_WR   = 4'd7;
    localparam logic [3:0] S_APPEND  = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                cmd.check  = 1'b1;
                state_next = S_DEC;
            end
            S_DEC: begin
                cmd.set_status = 1'b1;
                state_next     = S_OUT;
                case (stat.cmd)
                    pdq_pkg::CMD_ENQ: begin
                        if (stat.not_acc) begin
                            cmd.status = pdq_pkg::ST_NOT_ACCEPTING;
                        end else if (stat.after_bar) begin
                            cmd.status = pdq_pkg::ST_AFTER_BARRIER;
                        end else if (stat.set_full) begin
                            cmd.status = pdq_pkg::ST_SET_FULL;
                        end else if (stat.over_cap && stat.in_log) begin
                            cmd.status = pdq_pkg::ST_LOG_DROPPED;
                        end else if (stat.over_cap) begin
                            cmd.set_status = 1'b0;
                            cmd.idx_clr    = 1'b1;
                            state_next     = S_SCAN_RD;
                        end else begin
                            cmd.status = pdq_pkg::ST_ACCEPTED;
                            state_next = S_APPEND;
                        end
                    end
                    pdq_pkg::CMD_DEQ: begin
                        if (stat.occ_zero) begin
                            cmd.status = stat.stop_flag ? pdq_pkg::ST_CLOSED
                                                        : pdq_pkg::ST_EMPTY;
                        end else begin
                            cmd.status   = pdq_pkg::ST_POPPED;
                            cmd.rd_front = 1'b1;
                            state_next   = S_POP;
                        end
                    end
                    pdq_pkg::CMD_START: begin
                        cmd.do_start = 1'b1;
                        cmd.status   = pdq_pkg::ST_ACCEPTED;
                    end
                    default: begin
                        cmd.do_stop = 1'b1;
                        cmd.status  = (!stat.drain || stat.occ_zero) ? pdq_pkg::ST_CLOSED
                                                                      : pdq_pkg::ST_ACCEPTED;
                    end
                endcase
            end
            S_POP: begin
                cmd.pop    = 1'b1;
                state_next = S_OUT;
            end
            S_SCAN_RD: begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (stat.scan_log) begin
                    state_next = S_CP_RD;
                end else if (stat.idx_last) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = pdq_pkg::ST_FULL;
                    state_next     = S_OUT;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_CP_RD: begin
                if (stat.idx_last) begin
                    cmd.occ_dec    = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = pdq_pkg::ST_EVICTED;
                    state_next     = S_APPEND;
                end else begin
                    cmd.rd_copy = 1'b1;
                    state_next  = S_CP_WR;
                end
            end
            S_CP_WR: begin
                cmd.wr_copy = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_CP_RD;
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/priority_drop_queue_admission_unit.sv =====
// Top level of the priority drop queue admission unit.
// One item is handled at a time: check, decide, then pop for a dequeue, append for an
// admitted enqueue, and output. An enqueue into a full queue searches for the oldest log
// through the queue RAM read port, a read and a check state per entry, then shifts the
// later entries down, a read and a write state per entry. The result register is loaded
// when free, and the next item is taken as soon as it is.
module priority_drop_queue_admission_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [2:0]  s_item_type,
    input  logic [15:0] s_session_id,
    input  logic        s_has_session,
    input  logic [63:0] s_generation,
    input  logic [31:0] s_payload,
    input  logic        s_drain,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [2:0]  m_out_type,
    output logic [15:0] m_out_session,
    output logic        m_out_has_session,
    output logic [63:0] m_out_generation,
    output logic [31:0] m_out_payload,
    output logic        m_barrier_done,
    output logic [8:0]  m_depth_now
);

    pdq_pkg::dp_cmd_t  cmd;
    pdq_pkg::dp_stat_t stat;

    pdq_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    pdq_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_cmd            (s_cmd),
        .s_item_type      (s_item_type),
        .s_session_id     (s_session_id),
        .s_has_session    (s_has_session),
        .s_generation     (s_generation),
        .s_payload        (s_payload),
        .s_drain          (s_drain),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_out_type       (m_out_type),
        .m_out_session    (m_out_session),
        .m_out_has_session(m_out_has_session),
        .m_out_generation (m_out_generation),
        .m_out_payload    (m_out_payload),
        .m_barrier_done   (m_barrier_done),
        .m_depth_now      (m_depth_now)
    );

endmodule

// ===== sv/pdq_checker.sv =====
// Port-level checks for the priority drop queue admission unit, bound to the top level.
module pdq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_status,
    input logic [2:0]  m_out_type,
    input logic [31:0] m_out_payload,
    input logic        m_barrier_done,
    input logic [8:0]  m_depth_now
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_depth_now))
        else $error("result changed while stalled");

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != pdq_pkg::ST_POPPED) |->
            (m_out_payload == 32'd0) && !m_barrier_done && (m_out_type == 3'd0))
        else $error("item fields set on a non-pop result");

    a_barrier_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_barrier_done |-> m_out_type == pdq_pkg::TYPE_BARRIER)
        else $error("barrier flag on a non-barrier item");

    a_empty_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == pdq_pkg::ST_EMPTY) || (m_status == pdq_pkg::ST_CLOSED))
            |-> m_depth_now == 9'd0)
        else $error("empty or closed with items queued");

endmodule

bind priority_drop_queue_admission_unit pdq_checker u_pdq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_out_type    (m_out_type),
    .m_out_payload (m_out_payload),
    .m_barrier_done(m_barrier_done),
    .m_depth_now   (m_depth_now)
);

// ===== tb/sv/tb_priority_drop_queue_admission_unit.sv =====
// Self-checking testbench for the priority drop queue admission unit.
module tb_priority_drop_queue_admission_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [2:0]  s_item_type;
    logic [15:0] s_session_id;
    logic        s_has_session;
    logic [63:0] s_generation;
    logic [31:0] s_payload;
    logic        s_drain;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_status;
    logic [2:0]  m_out_type;
    logic [15:0] m_out_session;
    logic        m_out_has_session;
    logic [63:0] m_out_generation;
    logic [31:0] m_out_payload;
    logic        m_barrier_done;
    logic [8:0]  m_depth_now;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  out_type;
        logic [15:0] out_session;
        logic        out_has_session;
        logic [63:0] out_generation;
        logic [31:0] out_payload;
        logic        barrier_done;
        logic [8:0]  depth_now;
    } result_t;

    // queue model
    pdq_pkg::slot_t q_slots[$];
    logic [15:0]    barrier_sessions[$];
    logic           q_open;
    logic           q_stopping;
    logic [8:0]     q_max_depth;

    result_t     pending_results[$];
    int          errors;
    int          cycles;
    bit          rx_idle_on;
    bit          tx_idle_on;
    int          rx_hold;

    priority_drop_queue_admission_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_item_type(s_item_type), .s_session_id(s_session_id),
        .s_has_session(s_has_session), .s_generation(s_generation),
        .s_payload(s_payload), .s_drain(s_drain),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_type(m_out_type), .m_out_session(m_out_session),
        .m_out_has_session(m_out_has_session), .m_out_generation(m_out_generation),
        .m_out_payload(m_out_payload), .m_barrier_done(m_barrier_done),
        .m_depth_now(m_depth_now)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic in_barrier_set(logic [15:0] sess);
        foreach (barrier_sessions[i]) begin
            if (barrier_sessions[i] == sess) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [3:0] admit_item(pdq_pkg::slot_t it);
        int cap;
        int idx;
        logic [3:0] st;
        logic barrier;
        barrier = (it.item_type == pdq_pkg::TYPE_BARRIER);
        st = pdq_pkg::ST_ACCEPTED;
        idx = -1;
        if (!q_open || q_stopping) return pdq_pkg::ST_NOT_ACCEPTING;
        if (it.has_session && in_barrier_set(it.session_id))
            return pdq_pkg::ST_AFTER_BARRIER;
        if (barrier && it.has_session && barrier_sessions.size() >= pdq_pkg::BARRIER_SLOTS)
            return pdq_pkg::ST_SET_FULL;
        cap = q_max_depth;
        if (cap < 1) cap = 1;
        if (cap > pdq_pkg::QUEUE_SLOTS) cap = pdq_pkg::QUEUE_SLOTS;
        if (!barrier) cap = (cap > 1) ? cap - 1 : 1;
        if (q_slots.size() >= cap) begin
            if (pdq_pkg::is_log(it.item_type))
                return pdq_pkg::ST_LOG_DROPPED;
            foreach (q_slots[i]) begin
                if (idx < 0 && pdq_pkg::is_log(q_slots[i].item_type)) idx = i;
            end
            if (idx < 0) return pdq_pkg::ST_FULL;
            q_slots.delete(idx);
            st = pdq_pkg::ST_EVICTED;
        end
        if (q_slots.size() >= pdq_pkg::QUEUE_SLOTS) return pdq_pkg::ST_FULL;
        if (barrier && it.has_session) barrier_sessions.push_back(it.session_id);
        q_slots.push_back(it);
        return st;
    endfunction

    function automatic result_t predict_result(logic [1:0] cmd, pdq_pkg::slot_t it,
                                               logic drain);
        result_t r;
        pdq_pkg::slot_t f;
        r = '0;
        case (cmd)
            pdq_pkg::CMD_ENQ: begin
                r.status = admit_item(it);
            end
            pdq_pkg::CMD_DEQ: begin
                if (q_slots.size() == 0) begin
                    r.status = q_stopping ? pdq_pkg::ST_CLOSED : pdq_pkg::ST_EMPTY;
                end else begin
                    f = q_slots[0];
                    q_slots.delete(0);
                    r.status = pdq_pkg::ST_POPPED;
                    r.out_type = f.item_type;
                    r.out_session = f.session_id;
                    r.out_has_session = f.has_session;
                    r.out_generation = f.generation;
                    r.out_payload = f.payload;
                    r.barrier_done = (f.item_type == pdq_pkg::TYPE_BARRIER);
                end
            end
            pdq_pkg::CMD_START: begin
                if (!q_open) begin
                    q_slots.delete();
                    barrier_sessions.delete();
                    q_open = 1'b1;
                    q_stopping = 1'b0;
                end
                r.status = pdq_pkg::ST_ACCEPTED;
            end
            default: begin
                q_open = 1'b0;
                q_stopping = 1'b1;
                if (!drain) begin
                    q_slots.delete();
                    barrier_sessions.delete();
                end
                r.status = (q_slots.size() == 0) ? pdq_pkg::ST_CLOSED : pdq_pkg::ST_ACCEPTED;
            end
        endcase
        r.depth_now = 9'(q_slots.size());
        return r;
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [2:0] ty, logic [15:0] sess,
                             logic has, logic [63:0] gen, logic [31:0] pay, logic drain);
        pdq_pkg::slot_t it;
        it.item_type = ty;
        it.has_session = has;
        it.session_id = sess;
        it.generation = gen;
        it.payload = pay;
        while (tx_idle_on && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_item_type <= ty;
        s_session_id <= sess;
        s_has_session <= has;
        s_generation <= gen;
        s_payload <= pay;
        s_drain <= drain;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_result(cmd, it, drain));
        @(negedge aclk);
    endtask

    task automatic send_random(int sess_span, int enq_weight);
        logic [1:0] cmd;
        int r;
        r = $urandom_range(99);
        if (r < enq_weight) cmd = pdq_pkg::CMD_ENQ;
        else if (r < 94) cmd = pdq_pkg::CMD_DEQ;
        else if (r < 97) cmd = pdq_pkg::CMD_START;
        else cmd = pdq_pkg::CMD_STOP;
        send_item(cmd, 3'($urandom_range(7)), 16'($urandom_range(sess_span)),
                  1'($urandom), {$urandom, $urandom}, $urandom, 1'($urandom));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (700) @(negedge aclk);
    endtask

    task automatic write_depth(logic [8:0] d);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= d;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        q_max_depth = d;
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t exp;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_out_type, m_out_session, m_out_has_session,
                    m_out_generation, m_out_payload, m_barrier_done, m_depth_now};
            if (pending_results.size() == 0) begin
                $error("result with none expected: status %0d", got.status);
                errors++;
            end else begin
                exp = pending_results[0];
                pending_results.delete(0);
                if (got.status != exp.status) begin
                    $error("status exp %0d got %0d", exp.status, got.status); errors++;
                end
                if (got.out_type != exp.out_type) begin
                    $error("out_type exp %0d got %0d", exp.out_type, got.out_type); errors++;
                end
                if (got.out_session != exp.out_session) begin
                    $error("out_session exp %h got %h", exp.out_session, got.out_session);
                    errors++;
                end
                if (got.out_has_session != exp.out_has_session) begin
                    $error("out_has_session exp %0d got %0d", exp.out_has_session,
                           got.out_has_session);
                    errors++;
                end
                if (got.out_generation != exp.out_generation) begin
                    $error("out_generation exp %h got %h", exp.out_generation,
                           got.out_generation);
                    errors++;
                end
                if (got.out_payload != exp.out_payload) begin
                    $error("out_payload exp %h got %h", exp.out_payload, got.out_payload);
                    errors++;
                end
                if (got.barrier_done != exp.barrier_done) begin
                    $error("barrier_done exp %0d got %0d", exp.barrier_done,
                           got.barrier_done);
                    errors++;
                end
                if (got.depth_now != exp.depth_now) begin
                    $error("depth_now exp %0d got %0d", exp.depth_now, got.depth_now);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= !(rx_idle_on && $urandom_range(99) < 27);
        end
    end

    task automatic test_directed();
        send_item(pdq_pkg::CMD_ENQ, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        send_item(pdq_pkg::CMD_DEQ, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        send_item(pdq_pkg::CMD_START, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        send_item(pdq_pkg::CMD_START, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, pdq_pkg::TYPE_BARRIER, 16'hffff, 1'b1, '1, '1, 1'b1);
        send_item(pdq_pkg::CMD_ENQ, 3'd0, 16'hffff, 1'b1, 64'h1, 32'h1, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, pdq_pkg::TYPE_BARRIER, 16'h1234, 1'b0, 64'h2, 32'h2, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, 3'd6, 16'h0, 1'b1, 64'h3, 32'h3, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, 3'd7, 16'h5555, 1'b0, 64'h4, 32'h4, 1'b0);
        for (int t = 1; t <= 4; t++)
            send_item(pdq_pkg::CMD_ENQ, 3'(t), 16'(t), 1'b1, 64'(t), 32'(t), 1'b0);
        repeat (9) send_item(pdq_pkg::CMD_DEQ, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        send_item(pdq_pkg::CMD_STOP, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b1);
        send_item(pdq_pkg::CMD_DEQ, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
    endtask

    // tiny queue: eviction, log drop, full
    task automatic test_small_depth();
        write_depth(9'd3);
        send_item(pdq_pkg::CMD_START, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, pdq_pkg::TYPE_REQ_LOG, 16'h1, 1'b0, 64'h10, 32'h10, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, pdq_pkg::TYPE_RESP_LOG, 16'h2, 1'b0, 64'h11, 32'h11, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, pdq_pkg::TYPE_REQ_LOG, 16'h3, 1'b0, 64'h12, 32'h12, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, 3'd0, 16'h4, 1'b0, 64'h13, 32'h13, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, 3'd2, 16'h5, 1'b0, 64'h14, 32'h14, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, 3'd1, 16'h6, 1'b0, 64'h15, 32'h15, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, pdq_pkg::TYPE_BARRIER, 16'h7, 1'b1, 64'h16, 32'h16, 1'b0);
        send_item(pdq_pkg::CMD_ENQ, pdq_pkg::TYPE_BARRIER, 16'h8, 1'b1, 64'h17, 32'h17, 1'b0);
        send_item(pdq_pkg::CMD_STOP, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        for (int k = 0; k < 40; k++) send_random(15, 60);
        write_depth(9'd1);
        send_item(pdq_pkg::CMD_START, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        for (int k = 0; k < 30; k++) send_random(15, 60);
        write_depth(9'd0);
        for (int k = 0; k < 20; k++) send_random(15, 60);
    endtask

    // fill the barrier set
    task automatic test_barrier_set();
        write_depth(9'd256);
        send_item(pdq_pkg::CMD_STOP, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        send_item(pdq_pkg::CMD_START, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        for (int k = 0; k < 66; k++)
            send_item(pdq_pkg::CMD_ENQ, pdq_pkg::TYPE_BARRIER, 16'(k), 1'b1,
                      {$urandom, $urandom}, $urandom, 1'b0);
        for (int k = 0; k < 10; k++) send_random(127, 70);
    endtask

    // receiver holds off while the sender keeps going
    task automatic test_backpressure();
        write_depth(9'd40);
        send_item(pdq_pkg::CMD_STOP, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        send_item(pdq_pkg::CMD_START, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        s_valid <= 1'b0;
        @(negedge aclk);
        rx_hold <= 300;
        for (int k = 0; k < 20; k++) send_random(4095, 70);
        wait_drained();
    endtask

    task automatic test_random();
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        write_depth(9'd300);
        for (int k = 0; k < 60; k++) send_random(255, 60);
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        write_depth(9'(12 + $urandom_range(20)));
        send_item(pdq_pkg::CMD_START, 3'd0, 16'h0, 1'b0, 64'h0, 32'h0, 1'b0);
        for (int k = 0; k < 70; k++) send_random(63, 65);
        write_depth(9'd256);
        for (int k = 0; k < 60; k++) send_random(65535, 55);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        rx_hold = 0;
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        q_open = 1'b0;
        q_stopping = 1'b0;
        q_max_depth = 9'd256;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_cmd = pdq_pkg::CMD_ENQ;
        s_item_type = '0;
        s_session_id = '0;
        s_has_session = 1'b0;
        s_generation = '0;
        s_payload = '0;
        s_drain = 1'b0;
        m_ready = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_small_depth();
        test_barrier_set();
        test_backpressure();
        test_random();
        wait_drained();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
